// ===== hw/rtl/tmlc_pkg.sv =====
package tmlc_pkg;

    // Window geometry and trim.
    localparam int WINDOW = 20;
    localparam int TRIM   = 5;
    localparam int DATA_W = 16;
    localparam int IDX_W  = $clog2(WINDOW);

    // When the trim would leave nothing, it shrinks so that one or two samples remain.
    localparam int LO  = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
    localparam int HI  = WINDOW - LO;
    localparam int MID = HI - LO;

    localparam int SUM_W = DATA_W + $clog2(MID);

    // Scale to Q8 centimetres: level = (sum * LEVEL_MULT) >> SCALE_SHIFT.
    localparam int LEVEL_MULT  = 285213 / MID;
    localparam int MULT_W      = $clog2(LEVEL_MULT + 1);
    localparam int SCALE_SHIFT = 16;

    localparam int LEVEL_W  = 19;
    localparam int CHANGE_W = 20;
    localparam int INTAKE_W = 28;
    localparam int CFG_W    = 16;

    localparam int SCALE_W = (SUM_W + MULT_W > SCALE_SHIFT + LEVEL_W) ?
                             SUM_W + MULT_W : SCALE_SHIFT + LEVEL_W;

    localparam int AREA_SHIFT    = 8;
    localparam int INTAKE_PROD_W = CHANGE_W + CFG_W + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA      = 1'b1;

    localparam logic [CFG_W-1:0] TOLERANCE_RESET = 16'd128;
    localparam logic [CFG_W-1:0] AREA_RESET      = 16'd9856;

    typedef struct packed {
        logic [LEVEL_W-1:0]         level;
        logic                       is_new_level;
        logic                       alert;
        logic signed [CHANGE_W-1:0] change;
        logic signed [INTAKE_W-1:0] intake;
    } tmlc_result_t;

endpackage

// ===== hw/rtl/tmlc_window_mem.sv =====
module tmlc_window_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [tmlc_pkg::IDX_W-1:0]  waddr,
    input  logic [tmlc_pkg::DATA_W-1:0] wdata,
    input  logic [tmlc_pkg::IDX_W-1:0]  raddr_a,
    input  logic [tmlc_pkg::IDX_W-1:0]  raddr_b,
    output logic [tmlc_pkg::DATA_W-1:0] rdata_a,
    output logic [tmlc_pkg::DATA_W-1:0] rdata_b
);
    import tmlc_pkg::*;

    logic [DATA_W-1:0] mem [WINDOW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/tmlc_rank_sum.sv =====
module tmlc_rank_sum (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tmlc_pkg::DATA_W-1:0] rdata_a,
    input  logic [tmlc_pkg::DATA_W-1:0] rdata_b,
    output logic [tmlc_pkg::IDX_W-1:0]  raddr_a,
    output logic [tmlc_pkg::IDX_W-1:0]  raddr_b,
    output logic                        busy,
    output logic                        done,
    output logic [tmlc_pkg::SUM_W-1:0]  sum
);
    import tmlc_pkg::*;

    typedef enum logic [2:0] {R_IDLE, R_PIVOT, R_SCAN, R_LAST, R_ADD} rank_state_t;

    rank_state_t       state_reg;
    logic [IDX_W-1:0]  piv_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [IDX_W-1:0]  rank_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              done_reg;
    logic              less;
    logic              in_mid;

    // Port A holds the pivot for the whole scan; port B streams the window past it.
    assign raddr_a = piv_reg;
    assign raddr_b = scan_reg;

    // Equal samples are ordered by position, so every sample gets a distinct rank.
    assign less = (rdata_b < rdata_a) || ((rdata_b == rdata_a) && (cmp_idx_reg < piv_reg));

    assign in_mid = ({1'b0, rank_reg} >= (IDX_W + 1)'(LO)) &&
                    ({1'b0, rank_reg} <  (IDX_W + 1)'(HI));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= R_IDLE;
            piv_reg     <= '0;
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            rank_reg    <= '0;
            sum_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg    <= 1'b0;
            cmp_vld_reg <= (state_reg == R_SCAN);
            cmp_idx_reg <= scan_reg;
            if (cmp_vld_reg && less)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        piv_reg   <= '0;
                        sum_reg   <= '0;
                        state_reg <= R_PIVOT;
                    end
                end
                R_PIVOT:
                begin
                    rank_reg  <= '0;
                    scan_reg  <= '0;
                    state_reg <= R_SCAN;
                end
                R_SCAN:
                begin
                    if (scan_reg == IDX_W'(WINDOW - 1))
                    begin
                        state_reg <= R_LAST;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                R_LAST:
                begin
                    state_reg <= R_ADD;
                end
                R_ADD:
                begin
                    if (in_mid)
                    begin
                        sum_reg <= sum_reg + SUM_W'(rdata_a);
                    end
                    if (piv_reg == IDX_W'(WINDOW - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                    else
                    begin
                        piv_reg   <= piv_reg + 1'b1;
                        state_reg <= R_PIVOT;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != R_IDLE);
    assign done = done_reg;
    assign sum  = sum_reg;

endmodule

// ===== hw/rtl/tmlc_level_calc.sv =====
module tmlc_level_calc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tmlc_pkg::SUM_W-1:0] sum,
    input  logic [tmlc_pkg::CFG_W-1:0] tolerance,
    input  logic [tmlc_pkg::CFG_W-1:0] area,
    input  logic                       out_free,
    output logic                       busy,
    output logic                       res_vld,
    output tmlc_pkg::tmlc_result_t     result
);
    import tmlc_pkg::*;

    typedef enum logic [2:0] {P_IDLE, P_LEVEL, P_CHANGE, P_INTAKE, P_HOLD} post_state_t;

    post_state_t                     state_reg;
    logic [SCALE_W-1:0]              scale_reg;
    logic [LEVEL_W-1:0]              level_reg;
    logic [LEVEL_W-1:0]              old_level_reg;
    logic                            phase_reg;
    logic                            is_new_reg;
    logic                            alert_reg;
    logic signed [CHANGE_W-1:0]      change_reg;
    logic signed [INTAKE_PROD_W-1:0] prod_reg;
    logic signed [CHANGE_W-1:0]      diff;
    logic [CHANGE_W-1:0]             mag;

    assign diff = $signed({1'b0, old_level_reg}) - $signed({1'b0, level_reg});
    assign mag  = change_reg[CHANGE_W-1] ? CHANGE_W'(-change_reg) : CHANGE_W'(change_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= P_IDLE;
            scale_reg     <= '0;
            level_reg     <= '0;
            old_level_reg <= '0;
            phase_reg     <= 1'b0;
            is_new_reg    <= 1'b0;
            alert_reg     <= 1'b0;
            change_reg    <= '0;
            prod_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        scale_reg <= SCALE_W'(sum) * SCALE_W'(LEVEL_MULT);
                        state_reg <= P_LEVEL;
                    end
                end
                P_LEVEL:
                begin
                    level_reg <= scale_reg[SCALE_SHIFT +: LEVEL_W];
                    state_reg <= P_CHANGE;
                end
                P_CHANGE:
                begin
                    if (phase_reg)
                    begin
                        change_reg <= diff;
                        is_new_reg <= 1'b1;
                        phase_reg  <= 1'b0;
                    end
                    else
                    begin
                        old_level_reg <= level_reg;
                        change_reg    <= '0;
                        is_new_reg    <= 1'b0;
                        phase_reg     <= 1'b1;
                    end
                    state_reg <= P_INTAKE;
                end
                P_INTAKE:
                begin
                    // The signed product shifted right rounds towards minus infinity.
                    prod_reg  <= change_reg * $signed({1'b0, area});
                    alert_reg <= is_new_reg && (mag <= CHANGE_W'(tolerance));
                    state_reg <= P_HOLD;
                end
                P_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= P_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != P_IDLE);
    assign res_vld = (state_reg == P_HOLD);

    always_comb
    begin
        result.level        = level_reg;
        result.is_new_level = is_new_reg;
        result.alert        = alert_reg;
        result.change       = change_reg;
        result.intake       = prod_reg[AREA_SHIFT +: INTAKE_W];
    end

endmodule

// ===== hw/rtl/trimmed_mean_level_change_core.sv =====
// Result path: once the last item of a window is accepted, the rank scan runs, then u_calc
// steps through P_LEVEL, P_CHANGE, P_INTAKE and P_HOLD, and out_valid_reg drives out_valid.
// Input: 20 items are taken one per cycle, then the input stalls while both run (longer while a
// result waits at a stalled output); the rank scan, a window pass per pivot, dominates.
// Reset: asynchronous, active low; clears counters, phase, old level and restores
// tolerance 128 and area 9856. The window memory is not cleared.
module trimmed_mean_level_change_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tmlc_pkg::DATA_W-1:0]          echo_us,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tmlc_pkg::LEVEL_W-1:0]         level_q8,
    output logic                                 is_new_level,
    output logic                                 alert,
    output logic signed [tmlc_pkg::CHANGE_W-1:0] change_q8,
    output logic signed [tmlc_pkg::INTAKE_W-1:0] intake_q8,
    input  logic                                 cfg_we,
    input  logic [tmlc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tmlc_pkg::CFG_W-1:0]           cfg_data
);
    import tmlc_pkg::*;

    logic [CFG_W-1:0]  tolerance_reg;
    logic [CFG_W-1:0]  area_reg;
    logic [IDX_W-1:0]  count_reg;
    logic              out_valid_reg;
    tmlc_result_t      out_res_reg;

    logic              in_accept;
    logic              window_full;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;
    logic              rank_busy;
    logic              rank_done;
    logic [SUM_W-1:0]  rank_sum;
    logic              post_busy;
    logic              post_vld;
    logic              out_free;
    tmlc_result_t      post_res;

    assign in_stall    = rank_busy | rank_done | post_busy;
    assign in_accept   = in_valid && !in_stall;
    assign window_full = in_accept && (count_reg == IDX_W'(WINDOW - 1));
    assign out_free    = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOLERANCE_RESET;
            area_reg      <= AREA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOLERANCE: tolerance_reg <= cfg_data;
                CFG_AREA:      area_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_accept)
        begin
            count_reg <= window_full ? '0 : count_reg + 1'b1;
        end
    end

    tmlc_window_mem u_mem (
        .clk     (clk),
        .we      (in_accept),
        .waddr   (count_reg),
        .wdata   (echo_us),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    tmlc_rank_sum u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (window_full),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .busy    (rank_busy),
        .done    (rank_done),
        .sum     (rank_sum)
    );

    tmlc_level_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rank_done),
        .sum       (rank_sum),
        .tolerance (tolerance_reg),
        .area      (area_reg),
        .out_free  (out_free),
        .busy      (post_busy),
        .res_vld   (post_vld),
        .result    (post_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= post_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && post_vld)
        begin
            out_res_reg <= post_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign level_q8     = out_res_reg.level;
    assign is_new_level = out_res_reg.is_new_level;
    assign alert        = out_res_reg.alert;
    assign change_q8    = out_res_reg.change;
    assign intake_q8    = out_res_reg.intake;

endmodule

// ===== hw/rtl/tmlc_checker.sv =====
module tmlc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic [tmlc_pkg::DATA_W-1:0]          echo_us,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [tmlc_pkg::LEVEL_W-1:0]         level_q8,
    input logic                                 is_new_level,
    input logic                                 alert,
    input logic signed [tmlc_pkg::CHANGE_W-1:0] change_q8,
    input logic signed [tmlc_pkg::INTAKE_W-1:0] intake_q8
);
    import tmlc_pkg::*;

    // A stalled input item holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(echo_us))
        else $error("stalled input item changed");

    // A stalled result item holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level_q8) && $stable(change_q8)
            && $stable(intake_q8) && $stable(alert) && $stable(is_new_level))
        else $error("stalled result item changed");

    // An old-level result carries no change, no intake and no alert.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_new_level |-> (change_q8 == '0) && (intake_q8 == '0) && !alert)
        else $error("old-level result with non-zero change fields");

    // A level drop that is not negative never gives a negative intake.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !change_q8[CHANGE_W-1] |-> !intake_q8[INTAKE_W-1])
        else $error("intake sign disagrees with change sign");

    // A zero change gives zero intake.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (change_q8 == '0) |-> (intake_q8 == '0))
        else $error("zero change with non-zero intake");

endmodule

bind trimmed_mean_level_change_core tmlc_checker u_tmlc_checker (.*);
